@@ sv/tsm_pkg.sv @@
`timescale 1ns / 1ps
// tsm_pkg: shared sizes, codes, result type and helpers for the two-stack unit
// no dependencies
package tsm_pkg;

	localparam int DEPTH = 128;
	localparam int WIDTH = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [7:0] SIZE_RESET = 8'd128;

	typedef enum logic [2:0] {
		ACT_PUSH_ONE     = 3'd0,
		ACT_POP_ONE      = 3'd1,
		ACT_PUSH_TWO     = 3'd2,
		ACT_POP_TWO      = 3'd3,
		ACT_MOVE_ONE_TWO = 3'd4,
		ACT_MOVE_TWO_ONE = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} eng_state_t;

	typedef struct packed {
		logic [31:0] pop_value;
		status_t     status;
		logic [7:0]  count_one;
		logic [7:0]  count_two;
	} res_t;

	// configured size clamped to 2..DEPTH
	function automatic logic [CNT_W-1:0] eff_size(input logic [7:0] s);
		logic [CNT_W-1:0] r;
		if (s < 8'd2) begin
			r = CNT_W'(2);
		end else if (EXT_W'(s) > EXT_W'(DEPTH)) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(s);
		end
		return r;
	endfunction

	// sign-extend a stored word and keep the low 32 bits
	function automatic logic [31:0] to_out(input logic [WIDTH-1:0] v);
		logic signed [63:0] ext;
		ext = 64'(signed'(v));
		return ext[31:0];
	endfunction

endpackage

@@ sv/tsm_ram.sv @@
`timescale 1ns / 1ps
// tsm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tsm_ram #(
	parameter int ENTRIES = 128,
	parameter int DATA_W = 32
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [DATA_W-1:0]          rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [DATA_W-1:0]          wr_data
);

	logic [DATA_W-1:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/tsm_engine.sv @@
`timescale 1ns / 1ps
// tsm_engine: stack pointers, size register and read-modify-write sequencing
// depends on tsm_pkg; drives the ports of tsm_ram
module tsm_engine import tsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [7:0]        cfg_write_data,
	input  logic              in_valid,
	input  logic [2:0]        action,
	input  logic [31:0]       push_value,
	output logic              in_stall,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [WIDTH-1:0]  rd_data,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [WIDTH-1:0]  wr_data,
	input  logic              out_free,
	output logic              res_load,
	output res_t              res
);

	eng_state_t       state_q, state_nx;
	logic [7:0]       size_q;
	logic [CNT_W-1:0] depth_one_q, depth_two_q;
	logic [CNT_W-1:0] depth_one_nx, depth_two_nx;
	action_t          act_s1;
	logic [WIDTH-1:0] push_s1;

	logic [CNT_W-1:0] eff;
	logic             full;
	logic [CNT_W-1:0] top_two_rd;
	logic [CNT_W-1:0] top_two_wr;
	logic [CNT_W-1:0] top_one_rd;
	logic             commit;
	status_t          st;
	logic [31:0]      pop_val;

	assign eff = eff_size(size_q);
	assign full = ({1'b0, depth_one_q} + {1'b0, depth_two_q}) >= {1'b0, eff};
	assign top_one_rd = depth_one_q - CNT_W'(1);
	assign top_two_rd = eff - depth_two_q;
	assign top_two_wr = eff - CNT_W'(1) - depth_two_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				rd_en = in_valid;
			end
			S_RUN: begin
				commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// read address: top of the source stack for pops and moves
	always_comb begin
		if (action == ACT_POP_TWO || action == ACT_MOVE_TWO_ONE) begin
			rd_addr = top_two_rd[ADDR_W-1:0];
		end else begin
			rd_addr = top_one_rd[ADDR_W-1:0];
		end
	end

	// modify and write back
	always_comb begin
		wr_en = 1'b0;
		wr_addr = depth_one_q[ADDR_W-1:0];
		wr_data = push_s1;
		st = ST_OK;
		pop_val = '0;
		depth_one_nx = depth_one_q;
		depth_two_nx = depth_two_q;
		unique case (act_s1)
			ACT_PUSH_ONE: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					wr_en = commit;
					depth_one_nx = depth_one_q + CNT_W'(1);
				end
			end
			ACT_PUSH_TWO: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					wr_en = commit;
					wr_addr = top_two_wr[ADDR_W-1:0];
					depth_two_nx = depth_two_q + CNT_W'(1);
				end
			end
			ACT_POP_ONE: begin
				if (depth_one_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					pop_val = to_out(rd_data);
					depth_one_nx = top_one_rd;
				end
			end
			ACT_POP_TWO: begin
				if (depth_two_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					pop_val = to_out(rd_data);
					depth_two_nx = depth_two_q - CNT_W'(1);
				end
			end
			ACT_MOVE_ONE_TWO: begin
				if (depth_one_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					pop_val = to_out(rd_data);
					wr_en = commit;
					wr_addr = top_two_wr[ADDR_W-1:0];
					wr_data = rd_data;
					depth_one_nx = top_one_rd;
					depth_two_nx = depth_two_q + CNT_W'(1);
				end
			end
			ACT_MOVE_TWO_ONE: begin
				if (depth_two_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					pop_val = to_out(rd_data);
					wr_en = commit;
					wr_data = rd_data;
					depth_two_nx = depth_two_q - CNT_W'(1);
					depth_one_nx = depth_one_q + CNT_W'(1);
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign res_load = commit;
	assign res.pop_value = pop_val;
	assign res.status = st;
	assign res.count_one = 8'(depth_one_nx);
	assign res.count_two = 8'(depth_two_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= SIZE_RESET;
			depth_one_q <= '0;
			depth_two_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_write_en) begin
				// new size moves stack two, so both stacks empty
				size_q <= cfg_write_data;
				depth_one_q <= '0;
				depth_two_q <= '0;
			end else if (commit) begin
				depth_one_q <= depth_one_nx;
				depth_two_q <= depth_two_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			act_s1 <= action_t'(action);
			push_s1 <= WIDTH'(push_value);
		end
	end

endmodule

@@ sv/two_stacks_one_memory_unit.sv @@
`timescale 1ns / 1ps
// two_stacks_one_memory_unit: two stacks sharing one ram, with result register
// depends on tsm_pkg, tsm_ram and tsm_engine
// sequence: on accept the ram reads the source top; the engine then waits until the
//   output register is free, loads the result there and commits the write-back
// requests: no new request is taken until the last result is loaded; a stalled
//   result holds the engine until taken
// reset: both stacks empty, size 128; ram contents stay unknown, no clear pass
module two_stacks_one_memory_unit import tsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: shared size, a write empties both stacks
	input  logic        cfg_write_en,
	input  logic [7:0]  cfg_write_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] push_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pop_value,
	output logic [1:0]  status,
	output logic [7:0]  count_one,
	output logic [7:0]  count_two
);

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WIDTH-1:0]  rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WIDTH-1:0]  wr_data;
	logic              out_free;
	logic              res_load;
	res_t              res;

	logic              out_valid_q;
	res_t              out_res_q;

	// shared store: stack one from entry 0 up, stack two from size-1 down
	tsm_ram #(
		.ENTRIES(DEPTH),
		.DATA_W (WIDTH)
	) u_ram (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// pointer logic: reads the source top on accept, writes back when the result is loaded
	tsm_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.action        (action),
		.push_value    (push_value),
		.in_stall      (in_stall),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.out_free      (out_free),
		.res_load      (res_load),
		.res           (res)
	);

	// the output register can take a new result once the old one leaves
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = out_res_q.pop_value;
	assign status = out_res_q.status;
	assign count_one = out_res_q.count_one;
	assign count_two = out_res_q.count_two;

endmodule
